// ===== hdl/pci_pkg.sv =====
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types and constants for the palette color indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);
  localparam int POS_W        = 20;
  localparam int CHAN_W       = 8;
  localparam int COLOR_W      = 4 * CHAN_W;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CLIP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'b1;

  localparam logic [CFG_W-1:0] ALPHA_CLIP_RST  = 9'h1FF;
  localparam logic [2:0]       PIXEL_BYTES_RST = 3'd4;
  localparam logic [CHAN_W-1:0] CHAN_OPAQUE    = 8'hFF;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_ADDED    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   position;
    logic               restart;
    logic               last_pixel;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/palette_color_indexer_top.sv =====
// ----------------------------------------------------------------------------
// palette_color_indexer_top
// Builds a palette of up to 256 RGBA colors from a pixel stream and returns
// the palette index, status and color count for every pixel.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   cfg      | cfg_we               | cfg_index, cfg_data
//   pixel in | in_valid / in_ready  | red green blue alpha position restart
//            |                      | last_pixel
//   result   | out_valid/out_ready  | palette_index status out_position
//            |                      | color_count done_res
//
// Each item is matched by a linear scan of the N palette entries in use,
// at one palette RAM read per cycle.
// An overflowed palette returns each item without a palette scan.
// A two-item queue lets pixels be taken while the search engine is busy.
// Synchronous reset clears the count and overflow; palette RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_color_indexer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pci_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic [7:0]                    alpha,
  input  wire logic [pci_pkg::POS_W-1:0]     position,
  input  wire logic                          restart,
  input  wire logic                          last_pixel,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [7:0]                    palette_index,
  output      logic [1:0]                    status,
  output      logic [pci_pkg::POS_W-1:0]     out_position,
  output      logic [8:0]                    color_count,
  output      logic                          done_res
);

  pci_pkg::q_stat_t q_stat;
  pci_pkg::item_t   push_item;
  pci_pkg::item_t   head;
  logic             push;
  logic             pop;

  pci_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .position  (position),
    .restart   (restart),
    .last_pixel(last_pixel),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  pci_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  pci_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .palette_index(palette_index),
    .status       (status),
    .out_position (out_position),
    .color_count  (color_count),
    .done_res     (done_res)
  );

endmodule

`default_nettype wire

// ===== hdl/pci_ram.sv =====
// ----------------------------------------------------------------------------
// pci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/pci_front.sv =====
// ----------------------------------------------------------------------------
// pci_front
// Accepts pixels, narrows and clips them, and pushes the color into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pci_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic [7:0]                    alpha,
  input  wire logic [pci_pkg::POS_W-1:0]     position,
  input  wire logic                          restart,
  input  wire logic                          last_pixel,
  input  wire pci_pkg::q_stat_t              q_stat,
  output      logic                          push,
  output      pci_pkg::item_t                push_item
);

  logic [pci_pkg::CFG_W-1:0] alpha_clip;
  logic [2:0]                pixel_bytes;
  logic [2:0]                nb;
  logic [7:0]                g_n, b_n, a_n;
  logic                      clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_clip  <= pci_pkg::ALPHA_CLIP_RST;
      pixel_bytes <= pci_pkg::PIXEL_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pci_pkg::CFG_ALPHA_CLIP:  alpha_clip  <= cfg_data;
        pci_pkg::CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pixel_bytes == 3'd0) begin
      nb = 3'd1;
    end else if (pixel_bytes > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = pixel_bytes;
    end
    g_n  = (nb < 3'd2) ? 8'h00 : green;
    b_n  = (nb < 3'd3) ? 8'h00 : blue;
    a_n  = (nb < 3'd4) ? pci_pkg::CHAN_OPAQUE : alpha;
    clip = $signed({1'b0, a_n}) <= $signed(alpha_clip);
    push_item.color      = clip ? '0 : {a_n, b_n, g_n, red};
    push_item.position   = position;
    push_item.restart    = restart;
    push_item.last_pixel = last_pixel;
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

endmodule

`default_nettype wire

// ===== hdl/pci_queue.sv =====
// ----------------------------------------------------------------------------
// pci_queue
// Short item queue between the front and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pci_pkg::item_t push_item,
  input  wire logic           pop,
  output      pci_pkg::item_t head,
  output      pci_pkg::q_stat_t q_stat
);

  pci_pkg::item_t                slots [pci_pkg::Q_DEPTH];
  logic [pci_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [pci_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [pci_pkg::Q_PTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == (pci_pkg::Q_PTR_W+1)'(pci_pkg::Q_DEPTH);
  assign q_stat.empty = count == '0;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && q_stat.full))
    else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && q_stat.empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= (pci_pkg::Q_PTR_W+1)'(pci_pkg::Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/pci_back.sv =====
// ----------------------------------------------------------------------------
// pci_back
// Palette search engine: linear scan of the palette RAM, append on a miss while
// the palette has room, result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pci_pkg::q_stat_t          q_stat,
  input  wire pci_pkg::item_t            head,
  output      logic                      pop,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [7:0]                palette_index,
  output      logic [1:0]                status,
  output      logic [pci_pkg::POS_W-1:0] out_position,
  output      logic [8:0]                color_count,
  output      logic                      done_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [pci_pkg::CNT_W-1:0]       entries_used;
  logic                            overflowed;
  logic [pci_pkg::CNT_W-1:0]       scan;
  logic                            cmp_valid;
  logic [pci_pkg::IDX_W-1:0]       cmp_idx;
  pci_pkg::item_t                  cur;
  logic [pci_pkg::IDX_W-1:0]       res_idx;
  pci_pkg::status_t                res_status;
  logic [pci_pkg::CNT_W-1:0]       res_count;
  pci_pkg::status_t                out_status;

  logic [pci_pkg::COLOR_W-1:0]     rdata;
  logic                            hit;
  logic                            more;
  logic                            miss;
  logic                            room;
  logic                            ram_we;
  logic                            load_out;
  logic [pci_pkg::CNT_W-1:0]       used_n;

  assign hit      = state == S_SCAN && cmp_valid && rdata == cur.color;
  assign more     = scan < entries_used;
  assign miss     = state == S_SCAN && !cmp_valid && !more;
  assign room     = entries_used < pci_pkg::CNT_W'(pci_pkg::PALETTE_SIZE);
  assign ram_we   = miss && room;
  assign pop      = state == S_IDLE && !q_stat.empty;
  assign load_out = state == S_FINISH && (!out_valid || out_ready);
  assign used_n   = head.restart ? '0 : entries_used;

  pci_ram #(
    .WIDTH(pci_pkg::COLOR_W),
    .DEPTH(pci_pkg::PALETTE_SIZE)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entries_used[pci_pkg::IDX_W-1:0]),
    .wdata(cur.color),
    .raddr(scan[pci_pkg::IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entries_used <= '0;
      overflowed   <= 1'b0;
      cmp_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur          <= head;
            entries_used <= used_n;
            overflowed   <= overflowed && !head.restart;
            scan         <= '0;
            cmp_valid    <= 1'b0;
            if (overflowed && !head.restart) begin
              res_idx    <= '0;
              res_status <= pci_pkg::ST_OVERFLOW;
              res_count  <= used_n;
              state      <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            res_idx    <= cmp_idx;
            res_status <= pci_pkg::ST_FOUND;
            res_count  <= entries_used;
            cmp_valid  <= 1'b0;
            state      <= S_FINISH;
          end else if (more) begin
            scan      <= scan + 1'b1;
            cmp_valid <= 1'b1;
            cmp_idx   <= scan[pci_pkg::IDX_W-1:0];
          end else if (cmp_valid) begin
            cmp_valid <= 1'b0;
          end else if (room) begin
            res_idx      <= entries_used[pci_pkg::IDX_W-1:0];
            res_status   <= pci_pkg::ST_ADDED;
            res_count    <= entries_used + 1'b1;
            entries_used <= entries_used + 1'b1;
            state        <= S_FINISH;
          end else begin
            res_idx    <= '0;
            res_status <= pci_pkg::ST_OVERFLOW;
            res_count  <= entries_used;
            overflowed <= 1'b1;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            palette_index <= res_idx;
            out_status    <= res_status;
            out_position  <= cur.position;
            color_count   <= res_count;
            done_res      <= cur.last_pixel;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = out_status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      entries_used <= pci_pkg::CNT_W'(pci_pkg::PALETTE_SIZE))
    else $error("palette count beyond size");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
      overflowed |-> entries_used == pci_pkg::CNT_W'(pci_pkg::PALETTE_SIZE))
    else $error("overflow with room left");
  a_added_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_status == pci_pkg::ST_ADDED
      |-> {1'b0, palette_index} == color_count - 1'b1)
    else $error("added entry is not the newest");
  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_status == pci_pkg::ST_OVERFLOW |-> palette_index == '0)
    else $error("overflow result with nonzero index");
  a_write_scan: assert property (@(posedge clk) disable iff (rst)
      ram_we |-> !cmp_valid && scan == entries_used)
    else $error("palette append before scan finished");
`endif

endmodule

`default_nettype wire
